[rtl/tmps_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmps_pkg: shared types and constants of the trimmed-mean pH block
// Port widths, pH scaling constants, cell control, divider status and FSM encoding.
// ----------------------------------------------------------------------------
package tmps_pkg;

	localparam int SAMPLE_W   = 10;   // width of the sample port
	localparam int TSUM_W     = 13;   // width of trimmed_sum
	localparam int PH_W       = 17;   // width of ph_value
	localparam int PH_MUL     = 35;   // 5.0 * 3.5 * 2
	localparam int PH_FRAC    = 12;   // pH held in 1/4096 steps

	typedef struct packed {
		logic ins;    // insert the broadcast sample in order
		logic shift;  // move every entry one cell toward cell 0
	} cell_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_SUM,
		ST_PREP,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

[rtl/tmps_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmps_cell: one cell of the insertion chain
// Holds one ordered entry; on insert it keeps, takes the new sample or takes
// its lower neighbor's entry; on shift it takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module tmps_cell #(
	parameter int W = 10
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire tmps_pkg::cell_ctl_t ctl,
	input  wire  [W-1:0]            din,
	input  wire  [W-1:0]            left_val,
	input  wire                     left_valid,
	input  wire                     left_moves,
	input  wire  [W-1:0]            right_val,
	input  wire                     right_valid,
	output logic [W-1:0]            val,
	output logic                    valid,
	output logic                    moves
);

	logic [W-1:0] val_q;
	logic         valid_q;
	logic         take;

	// an empty cell counts as holding +infinity
	assign take  = !valid_q || (din < val_q);
	assign moves = valid_q && (din < val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= right_valid;
		end else if (ctl.ins && take && left_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= right_val;
		end else if (ctl.ins && take) begin
			if (left_moves) begin
				val_q <= left_val;
			end else if (left_valid) begin
				val_q <= din;
			end
		end
	end

	assign val   = val_q;
	assign valid = valid_q;

endmodule
`default_nettype wire

[rtl/tmps_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmps_div: divider by a fixed constant
// Reciprocal multiplication: the dividend is registered, then one multiply
// and shift gives the quotient, which is registered as well.
// ----------------------------------------------------------------------------
module tmps_div #(
	parameter int W       = 23,
	parameter int DIVISOR = 6
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire  [W-1:0]            dividend,
	output tmps_pkg::div_stat_t     stat,
	output logic [W-1:0]            quotient
);

	// m = ceil(2^(W+l) / d), l = ceil(log2 d): exact for every W-bit dividend
	localparam int              SH    = W + $clog2(DIVISOR);
	localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) /
	                                    64'(DIVISOR);
	localparam int              PW    = 2 * W + 1;

	logic [W-1:0]  x_q;
	logic [W-1:0]  quo_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    recip;
	logic [PW-1:0] prod;

	assign recip = (W+1)'(RECIP);
	assign prod  = PW'(x_q) * PW'(recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
		end
		if (busy_q) begin
			quo_q <= W'(prod >> SH);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
`default_nettype wire

[rtl/trimmed_mean_ph_sensor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trimmed_mean_ph_sensor: trimmed mean of a sample batch with pH scaling
// Orders each batch of samples, drops the extremes, sums the rest and
// scales the sum to pH in 1/4096 steps.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a batch fills; each one is placed in
// order by a chain of BATCH_SIZE insertion cells as it arrives. After the
// last sample of a batch, in_ready stays low while the chain shifts its
// BATCH_SIZE entries out through the accumulator, through a setup state,
// the constant divider that scales the sum (dividend register, then one
// reciprocal multiply) and the state that loads the result register.
// At the defaults a batch is 10 samples. If the previous result has not
// been taken, the block waits for it before loading the new one.
module trimmed_mean_ph_sensor #(
	parameter int BATCH_SIZE    = 10,
	parameter int TRIM_EACH_END = 2,
	parameter int SAMPLE_BITS   = 10
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [tmps_pkg::SAMPLE_W-1:0]  sample,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [tmps_pkg::TSUM_W-1:0]    trimmed_sum,
	output logic [tmps_pkg::PH_W-1:0]      ph_value
);

	localparam int CENTRE  = BATCH_SIZE - 2 * TRIM_EACH_END;
	localparam int DIVISOR = (CENTRE > 0) ? CENTRE : 1;
	localparam int CNT_W   = $clog2(BATCH_SIZE);
	localparam int SUM_W   = SAMPLE_BITS + $clog2(BATCH_SIZE + 1);
	localparam int M_W     = SUM_W + 9;
	localparam int SCALE_B = SAMPLE_BITS + 1;   // log2 of 2 * 2^SAMPLE_BITS
	localparam int SATS_W  = SUM_W + tmps_pkg::TSUM_W;
	localparam int SATP_W  = M_W + tmps_pkg::PH_W;
	localparam int SAMPLE_W_EXT = tmps_pkg::SAMPLE_W + SAMPLE_BITS;

	tmps_pkg::state_t    state_q, state_d;
	tmps_pkg::cell_ctl_t ctl;
	tmps_pkg::div_stat_t div_stat;

	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       idx_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   in_fire;
	logic                   last_in;
	logic                   div_start;
	logic                   out_load;
	logic                   acc_win;
	logic [SAMPLE_W_EXT-1:0] sample_x;
	logic [SAMPLE_BITS-1:0] din;
	logic [M_W-1:0]         prod;
	logic [M_W-1:0]         dividend;
	logic [M_W-1:0]         quotient;
	logic [SATS_W-1:0]      sum_x;
	logic [SATP_W-1:0]      ph_x;

	logic [SAMPLE_BITS-1:0] cell_val [BATCH_SIZE];
	logic [BATCH_SIZE-1:0]  cell_valid;
	logic [BATCH_SIZE-1:0]  cell_moves;

	// only the low SAMPLE_BITS bits of a sample count
	assign sample_x = SAMPLE_W_EXT'(sample);
	assign din      = sample_x[SAMPLE_BITS-1:0];

	assign in_fire = in_valid && in_ready;
	assign last_in = (cnt_q == CNT_W'(BATCH_SIZE - 1));

	// ---------------- insertion chain ----------------
	for (genvar i = 0; i < BATCH_SIZE; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] lv, rv;
		logic                   lvalid, lmoves, rvalid;
		if (i == 0) begin : g_first
			assign lv     = '0;
			assign lvalid = 1'b1;
			assign lmoves = 1'b0;
		end else begin : g_mid
			assign lv     = cell_val[i-1];
			assign lvalid = cell_valid[i-1];
			assign lmoves = cell_moves[i-1];
		end
		if (i == BATCH_SIZE - 1) begin : g_last
			assign rv     = '0;
			assign rvalid = 1'b0;
		end else begin : g_inner
			assign rv     = cell_val[i+1];
			assign rvalid = cell_valid[i+1];
		end
		tmps_cell #(
			.W (SAMPLE_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.din         (din),
			.left_val    (lv),
			.left_valid  (lvalid),
			.left_moves  (lmoves),
			.right_val   (rv),
			.right_valid (rvalid),
			.val         (cell_val[i]),
			.valid       (cell_valid[i]),
			.moves       (cell_moves[i])
		);
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmps_pkg::ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ctl.ins   = 1'b0;
		ctl.shift = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			tmps_pkg::ST_FILL: begin
				in_ready = 1'b1;
				ctl.ins  = in_valid;
				if (in_valid && last_in) begin
					state_d = tmps_pkg::ST_SUM;
				end
			end
			tmps_pkg::ST_SUM: begin
				ctl.shift = 1'b1;
				if (idx_q == CNT_W'(BATCH_SIZE - 1)) begin
					state_d = tmps_pkg::ST_PREP;
				end
			end
			tmps_pkg::ST_PREP: begin
				div_start = 1'b1;
				state_d   = tmps_pkg::ST_DIV;
			end
			tmps_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_d = tmps_pkg::ST_OUT;
				end
			end
			tmps_pkg::ST_OUT: begin
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					state_d  = tmps_pkg::ST_FILL;
				end
			end
			default: begin
				state_d = tmps_pkg::ST_FILL;
			end
		endcase
	end

	// cell 0 presents the ordered entries one by one during the shift-out
	assign acc_win = (idx_q >= CNT_W'(TRIM_EACH_END)) &&
	                 ({1'b0, idx_q} < (CNT_W+1)'(BATCH_SIZE - TRIM_EACH_END));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (in_fire) begin
				cnt_q <= last_in ? '0 : cnt_q + CNT_W'(1);
			end
			if (ctl.shift) begin
				idx_q <= (idx_q == CNT_W'(BATCH_SIZE - 1)) ? '0 : idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && last_in) begin
			sum_q <= '0;
		end else if (ctl.shift && acc_win) begin
			sum_q <= sum_q + SUM_W'(cell_val[0]);
		end
	end

	// ---------------- pH scaling ----------------
	// ph = floor(sum * 35 * 2^12 / (2^(SAMPLE_BITS+1) * centre))
	assign prod = M_W'(sum_q) * M_W'(tmps_pkg::PH_MUL);

	if (SCALE_B <= tmps_pkg::PH_FRAC) begin : g_shl
		assign dividend = prod << (tmps_pkg::PH_FRAC - SCALE_B);
	end else begin : g_shr
		assign dividend = prod >> (SCALE_B - tmps_pkg::PH_FRAC);
	end

	tmps_div #(
		.W       (M_W),
		.DIVISOR (DIVISOR)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// ---------------- result register ----------------
	assign sum_x = SATS_W'(sum_q);
	assign ph_x  = SATP_W'(quotient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			trimmed_sum <= (sum_x > SATS_W'((1 << tmps_pkg::TSUM_W) - 1)) ?
			               '1 : sum_x[tmps_pkg::TSUM_W-1:0];
			ph_value    <= (ph_x > SATP_W'((1 << tmps_pkg::PH_W) - 1)) ?
			               '1 : ph_x[tmps_pkg::PH_W-1:0];
		end
	end

	// ---------------- checks ----------------
	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tmps_pkg::ST_FILL |-> $countones(cell_valid) == int'(cnt_q))
		else $error("chain occupancy does not match batch count");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last_in |=> !in_ready)
		else $error("request taken after the batch was complete");

	a_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tmps_pkg::ST_PREP |-> cell_valid == '0)
		else $error("chain not empty after shift-out");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

endmodule
`default_nettype wire
